// ----- hdl/rbsb_pkg.sv -----
// Shared types, constants and tables for the rigid box step unit.
// No dependencies.
package rbsb_pkg;

    localparam int TrigIterationsDefault = 16;
    localparam int ArcCount = 30;

    localparam logic [31:0] InvMassReset    = 32'd65536;
    localparam logic [31:0] InvInertiaReset = 32'd65536;
    localparam logic [30:0] HalfReset       = 31'd32768;
    localparam logic [16:0] StepReset       = 17'd1092;
    localparam logic [16:0] StepOne         = 17'd65536;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_INV_MASS    = 3'd0,
        REG_INV_INERTIA = 3'd1,
        REG_HALF_WIDTH  = 3'd2,
        REG_HALF_HEIGHT = 3'd3,
        REG_TIME_STEP   = 3'd4,
        REG_START_X     = 3'd5,
        REG_START_Y     = 3'd6
    } reg_idx_t;

    // multiplier operand selects, one product per sequencer step
    typedef enum logic [3:0] {
        OP_SPIN, OP_VX, OP_VY, OP_PX, OP_PY, OP_HEAD,
        OP_HWC, OP_HHS, OP_HWS, OP_HHC
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_CORDIC_START, ST_CORDIC,
        ST_CORNER, ST_CORNER_ACC, ST_BOUND, ST_OUT
    } state_t;

    typedef struct packed {
        logic    load;        // capture input word
        logic    mul_go;      // register a product
        mul_op_t op;
        logic    acc;         // apply product to state
        logic    cordic_init;
        logic    cordic_step;
        logic    bound;       // form corner bounds
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic cordic_done;
    } stat_t;

    function automatic logic signed [33:0] arc(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                5'd0: v = 34'sd536870912;  5'd1: v = 34'sd316933406;
                5'd2: v = 34'sd167458907;  5'd3: v = 34'sd85004756;
                5'd4: v = 34'sd42667331;   5'd5: v = 34'sd21354465;
                5'd6: v = 34'sd10679838;   5'd7: v = 34'sd5340245;
                5'd8: v = 34'sd2670163;    5'd9: v = 34'sd1335087;
                5'd10: v = 34'sd667544;    5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;    5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;     5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;     5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;      5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;       5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;       5'd23: v = 34'sd81;
                5'd24: v = 34'sd41;        5'd25: v = 34'sd20;
                5'd26: v = 34'sd10;        5'd27: v = 34'sd5;
                5'd28: v = 34'sd3;         5'd29: v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

// ----- hdl/rbsb_ctrl.sv -----
// Sequencer for the rigid box step unit: steps the shared multiplier,
// the CORDIC iterations and the bound phase. Uses rbsb_pkg.
module rbsb_ctrl
    import rbsb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    logic    out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SPIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    // a new word may enter while the last result still waits
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_SPIN;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (op_reg == OP_HEAD)
                    state_next = ST_CORDIC_START;
                else
                begin
                    op_next    = mul_op_t'(op_reg + 4'd1);
                    state_next = ST_MUL;
                end
            end
            ST_CORDIC_START:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_done)
                begin
                    op_next    = OP_HWC;
                    state_next = ST_CORNER;
                end
            end
            ST_CORNER:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_CORNER_ACC;
            end
            ST_CORNER_ACC:
            begin
                cmd.acc = 1'b1;
                if (op_reg == OP_HHC)
                    state_next = ST_BOUND;
                else
                begin
                    op_next    = mul_op_t'(op_reg + 4'd1);
                    state_next = ST_CORNER;
                end
            end
            ST_BOUND:
            begin
                cmd.bound  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/rbsb_datapath.sv -----
// Datapath of the rigid box step unit: registers, shared multiplier,
// CORDIC unit and bound logic. Uses rbsb_pkg.
module rbsb_datapath
    import rbsb_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TrigIterationsDefault
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic [95:0]   in_data,
    input  cmd_t          cmd,
    output stat_t         stat,
    output logic [319:0]  out_data
);

    localparam int IterCount = (TRIG_ITERATIONS > ArcCount) ? ArcCount : TRIG_ITERATIONS;
    localparam logic [4:0] IterLast = 5'(IterCount - 1);

    logic [31:0] inv_mass_reg, inv_inertia_reg;
    logic [30:0] half_w_reg, half_h_reg;
    logic [16:0] step_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg, spin_reg;
    logic [31:0] heading_reg;
    logic signed [31:0] push_x_reg, push_y_reg, twist_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] hwc_reg, hhs_reg, hws_reg, hhc_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]  iter_reg;
    logic        flip_reg;
    logic signed [31:0] lox_reg, hix_reg, loy_reg, hiy_reg;
    logic [319:0] out_reg;

    logic [16:0] dt;
    assign dt = (step_reg > StepOne) ? StepOne : step_reg;

    // shared multiplier operands, at most 33 x 33 signed
    logic signed [32:0] ma, mb;
    logic signed [33:0] cos_v, sin_v;
    assign cos_v = flip_reg ? -cx_reg : cx_reg;
    assign sin_v = flip_reg ? -cy_reg : cy_reg;

    always_comb
    begin
        case (cmd.op)
            OP_SPIN: begin ma = 33'(twist_reg);  mb = {1'b0, inv_inertia_reg}; end
            OP_VX:   begin ma = 33'(push_x_reg); mb = {1'b0, inv_mass_reg}; end
            OP_VY:   begin ma = 33'(push_y_reg); mb = {1'b0, inv_mass_reg}; end
            OP_PX:   begin ma = 33'(vel_x_reg);  mb = 33'({16'd0, dt}); end
            OP_PY:   begin ma = 33'(vel_y_reg);  mb = 33'({16'd0, dt}); end
            OP_HEAD: begin ma = 33'(spin_reg);   mb = 33'({16'd0, dt}); end
            OP_HWC:  begin ma = {2'b00, half_w_reg}; mb = cos_v[32:0]; end
            OP_HHS:  begin ma = {2'b00, half_h_reg}; mb = sin_v[32:0]; end
            OP_HWS:  begin ma = {2'b00, half_w_reg}; mb = sin_v[32:0]; end
            OP_HHC:  begin ma = {2'b00, half_h_reg}; mb = cos_v[32:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    logic signed [63:0] step_sum;
    assign step_sum = 64'(prod_reg >>> 16);

    // corner offsets: a = hw*c, b = hh*s, d = hw*s, e = hh*c
    logic signed [65:0] ox_p, ox_m, oy_p, oy_m;
    logic signed [65:0] ax_p, ax_m, ay_p, ay_m, mag_x, mag_y;
    logic signed [33:0] hi_dx, lo_dx, hi_dy, lo_dy;
    assign ox_p = 66'(hwc_reg) - 66'(hhs_reg);
    assign ox_m = 66'(hwc_reg) + 66'(hhs_reg);
    assign oy_p = 66'(hws_reg) + 66'(hhc_reg);
    assign oy_m = 66'(hws_reg) - 66'(hhc_reg);
    // corners come in opposite pairs, so each axis spans -mag..+mag before the shift
    assign ax_p = ox_p[65] ? -ox_p : ox_p;
    assign ax_m = ox_m[65] ? -ox_m : ox_m;
    assign ay_p = oy_p[65] ? -oy_p : oy_p;
    assign ay_m = oy_m[65] ? -oy_m : oy_m;
    assign mag_x = (ax_p > ax_m) ? ax_p : ax_m;
    assign mag_y = (ay_p > ay_m) ? ay_p : ay_m;
    assign hi_dx = 34'(mag_x >>> 30);
    assign lo_dx = 34'((-mag_x) >>> 30);
    assign hi_dy = 34'(mag_y >>> 30);
    assign lo_dy = 34'((-mag_y) >>> 30);

    logic signed [33:0] ang;
    assign ang = 34'(signed'(heading_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg    <= InvMassReset;
            inv_inertia_reg <= InvInertiaReset;
            half_w_reg      <= HalfReset;
            half_h_reg      <= HalfReset;
            step_reg        <= StepReset;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            vel_x_reg       <= '0;
            vel_y_reg       <= '0;
            spin_reg        <= '0;
            heading_reg     <= '0;
            iter_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_INV_MASS:    inv_mass_reg    <= cfg_data;
                    REG_INV_INERTIA: inv_inertia_reg <= cfg_data;
                    REG_HALF_WIDTH:  half_w_reg      <= cfg_data[30:0];
                    REG_HALF_HEIGHT: half_h_reg      <= cfg_data[30:0];
                    REG_TIME_STEP:   step_reg        <= cfg_data[16:0];
                    REG_START_X:     pos_x_reg       <= cfg_data;
                    REG_START_Y:     pos_y_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.acc)
            begin
                case (cmd.op)
                    OP_SPIN: spin_reg  <= sat32(64'(spin_reg) + step_sum);
                    OP_VX:   vel_x_reg <= sat32(64'(vel_x_reg) + step_sum);
                    OP_VY:   vel_y_reg <= sat32(64'(vel_y_reg) + step_sum);
                    OP_PX:   pos_x_reg <= sat32(64'(pos_x_reg) + step_sum);
                    OP_PY:   pos_y_reg <= sat32(64'(pos_y_reg) + step_sum);
                    OP_HEAD: heading_reg <= heading_reg + step_sum[31:0];
                    default: ;
                endcase
            end
            if (cmd.cordic_init)
                iter_reg <= '0;
            else if (cmd.cordic_step)
                iter_reg <= iter_reg + 5'd1;
        end
    end

    assign stat.cordic_done = (iter_reg == IterLast);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            push_x_reg <= in_data[31:0];
            push_y_reg <= in_data[63:32];
            twist_reg  <= in_data[95:64];
        end
        if (cmd.mul_go)
            prod_reg <= 66'(ma * mb);
        if (cmd.acc)
        begin
            case (cmd.op)
                OP_HWC: hwc_reg <= prod_reg[63:0];
                OP_HHS: hhs_reg <= prod_reg[63:0];
                OP_HWS: hws_reg <= prod_reg[63:0];
                OP_HHC: hhc_reg <= prod_reg[63:0];
                default: ;
            endcase
        end
        if (cmd.cordic_init)
        begin
            cx_reg <= CordicGain;
            cy_reg <= '0;
            // fold into a quarter turn either side of zero
            if (ang > 34'sd1073741824)
            begin
                cz_reg <= ang - 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else if (ang < -34'sd1073741824)
            begin
                cz_reg <= ang + 34'sd2147483648;
                flip_reg <= 1'b1;
            end
            else
            begin
                cz_reg <= ang;
                flip_reg <= 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - (cy_reg >>> iter_reg);
                cy_reg <= cy_reg + (cx_reg >>> iter_reg);
                cz_reg <= cz_reg - arc(iter_reg);
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> iter_reg);
                cy_reg <= cy_reg - (cx_reg >>> iter_reg);
                cz_reg <= cz_reg + arc(iter_reg);
            end
        end
        if (cmd.bound)
        begin
            hix_reg <= sat32(64'(pos_x_reg) + 64'(hi_dx));
            lox_reg <= sat32(64'(pos_x_reg) + 64'(lo_dx));
            hiy_reg <= sat32(64'(pos_y_reg) + 64'(hi_dy));
            loy_reg <= sat32(64'(pos_y_reg) + 64'(lo_dy));
        end
        if (cmd.out_load)
            out_reg <= {hiy_reg, loy_reg, hix_reg, lox_reg, spin_reg,
                        vel_y_reg, vel_x_reg, heading_reg, pos_y_reg, pos_x_reg};
    end

    assign out_data = out_reg;

endmodule

// ----- hdl/rigid_box_step_with_bounds_unit.sv -----
// Top level of the rigid box step unit: controller plus datapath.
// Depends on rbsb_pkg, rbsb_ctrl and rbsb_datapath.
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   push_x, push_y, twist
//  m_axis   out  m_axis_tvalid/tready   ten result fields
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The shared multiplier and the CORDIC loop set how long a word takes, and a new
// word is taken only once the last has reached the output register. Reset
// restores register defaults and clears state.
// A stalled result is held in the output register; the next word waits only
// if its result is ready before the old one leaves.
module rigid_box_step_with_bounds_unit
    import rbsb_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TrigIterationsDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // push_x, push_y, twist
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // center_x, center_y, heading_out, speed_x, speed_y, spin_out,
    // bound_left, bound_right, bound_bottom, bound_top
    output logic [319:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    rbsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbsb_datapath #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_axis_tdata)
    );

endmodule

// ----- test/tb_rigid_box_step_with_bounds_unit.sv -----
// Self-checking bench for rigid_box_step_with_bounds_unit: random and directed
// force/torque words, register phases, and a built-in box integrator model.
// Depends on rbsb_pkg and the unit RTL.
module tb_rigid_box_step_with_bounds_unit
    import rbsb_pkg::*;
();

    localparam int Iters = TrigIterationsDefault;

    typedef struct packed {
        logic signed [31:0] twist;
        logic signed [31:0] push_y;
        logic signed [31:0] push_x;
    } force_word_t;

    typedef struct packed {
        logic signed [31:0] bound_top;
        logic signed [31:0] bound_bottom;
        logic signed [31:0] bound_right;
        logic signed [31:0] bound_left;
        logic signed [31:0] spin_out;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_x;
        logic [31:0]        heading_out;
        logic signed [31:0] center_y;
        logic signed [31:0] center_x;
    } body_state_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [319:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // model registers and body state
    logic [31:0] inv_mass, inv_inertia;
    logic [30:0] half_w, half_h;
    logic [16:0] dt_reg;
    logic signed [31:0] px, py, vx, vy, spin_v;
    logic [31:0] head;

    force_word_t pending_forces[$];
    body_state_t expected_states[$];
    int gap_left, stall_left, errors, words_sent, words_checked;
    bit driving_done;

    rigid_box_step_with_bounds_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint arc_angle(int i);
        longint arcs[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1};
        return arcs[i];
    endfunction

    // advance the body one step and return the expected result word
    function automatic body_state_t integrate_step(force_word_t f);
        longint dt, a, x, y, z, dx, dy, c, s, hw, hh, ex, ey, cx, cy;
        longint lo_x, hi_x, lo_y, hi_y;
        bit flip;
        body_state_t r;
        dt = (dt_reg > StepOne) ? 65536 : longint'(dt_reg);
        spin_v = clamp(longint'(spin_v) + floor_shr(longint'(f.twist) * longint'(inv_inertia), 16));
        vx = clamp(longint'(vx) + floor_shr(longint'(f.push_x) * longint'(inv_mass), 16));
        vy = clamp(longint'(vy) + floor_shr(longint'(f.push_y) * longint'(inv_mass), 16));
        px = clamp(longint'(px) + floor_shr(longint'(vx) * dt, 16));
        py = clamp(longint'(py) + floor_shr(longint'(vy) * dt, 16));
        head = 32'(longint'(head) + floor_shr(longint'(spin_v) * dt, 16));
        a = longint'($signed(head));
        flip = 0;
        if (a > 64'sd1073741824)
        begin
            a -= 64'sd2147483648;
            flip = 1;
        end
        else if (a < -64'sd1073741824)
        begin
            a += 64'sd2147483648;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = a;
        for (int i = 0; i < Iters && i < 30; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arc_angle(i);
            end
            else
            begin
                x += dx; y -= dy; z += arc_angle(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        hw = half_w;
        hh = half_h;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
        for (int k = 0; k < 4; k++)
        begin
            ex = (k == 0 || k == 3) ? hw : -hw;
            ey = (k < 2) ? hh : -hh;
            cx = longint'(px) + floor_shr(ex * c - ey * s, 30);
            cy = longint'(py) + floor_shr(ex * s + ey * c, 30);
            if (k == 0 || cx < lo_x) lo_x = cx;
            if (k == 0 || cx > hi_x) hi_x = cx;
            if (k == 0 || cy < lo_y) lo_y = cy;
            if (k == 0 || cy > hi_y) hi_y = cy;
        end
        r.center_x = px;
        r.center_y = py;
        r.heading_out = head;
        r.speed_x = vx;
        r.speed_y = vy;
        r.spin_out = spin_v;
        r.bound_left = clamp(lo_x);
        r.bound_right = clamp(hi_x);
        r.bound_bottom = clamp(lo_y);
        r.bound_top = clamp(hi_y);
        return r;
    endfunction

    // sampled handshakes used by the falling-edge driver and sink
    logic s_fire, m_fire;
    always @(posedge clk)
    begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
    end

    // source: word leaves the queue when accepted, the next follows its gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_fire && s_axis_tvalid)
        begin
            force_word_t sent;
            sent = pending_forces.pop_front();
            expected_states.insert(expected_states.size(), integrate_step(sent));
            words_sent++;
            gap_left = $urandom_range(0, 5);
            if (gap_left == 0 && pending_forces.size() != 0)
            begin
                s_axis_tdata <= pending_forces[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid && !driving_done && pending_forces.size() != 0)
        begin
            if (gap_left == 0)
            begin
                s_axis_tdata <= pending_forces[0];
                s_axis_tvalid <= 1'b1;
            end
            else
                gap_left--;
        end
    end

    // sink: random stalls on the result side
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (m_fire || !m_axis_tready)
        begin
            if (stall_left == 0 || m_fire)
            begin
                if (m_fire)
                    stall_left = $urandom_range(0, 5);
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    stall_left--;
                end
            end
            else
                stall_left--;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        body_state_t seen, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata;
            words_checked++;
            if (expected_states.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", seen);
            end
            else
            begin
                want = expected_states.pop_front();
                if (seen !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch word %0d\n  exp %h\n  got %h",
                                 words_checked, want, seen);
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INV_MASS:    inv_mass = value;
            REG_INV_INERTIA: inv_inertia = value;
            REG_HALF_WIDTH:  half_w = value[30:0];
            REG_HALF_HEIGHT: half_h = value[30:0];
            REG_TIME_STEP:   dt_reg = value[16:0];
            REG_START_X:     px = value;
            REG_START_Y:     py = value;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_edge32();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return 32'hffffffff;
            4: return $urandom_range(0, 2 * 65536) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // queue a batch and wait until every prediction is matched
    task automatic run_batch(int n, bit edgy);
        force_word_t f;
        for (int i = 0; i < n; i++)
        begin
            f.push_x = edgy ? rand_edge32() : $signed($urandom_range(0, 8192)) - 4096;
            f.push_y = edgy ? rand_edge32() : $signed($urandom_range(0, 8192)) - 4096;
            f.twist = edgy ? rand_edge32() : $urandom;
            pending_forces.insert(pending_forces.size(), f);
        end
        while (pending_forces.size() != 0 || expected_states.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic queue_force(logic [31:0] fx, logic [31:0] fy, logic [31:0] tq);
        force_word_t f;
        f.push_x = fx;
        f.push_y = fy;
        f.twist = tq;
        pending_forces.insert(pending_forces.size(), f);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INV_MASS;
        cfg_data = '0;
        errors = 0; words_sent = 0; words_checked = 0;
        gap_left = 0; stall_left = 0; driving_done = 0;
        inv_mass = InvMassReset; inv_inertia = InvInertiaReset;
        half_w = HalfReset; half_h = HalfReset; dt_reg = StepReset;
        px = 0; py = 0; vx = 0; vy = 0; spin_v = 0; head = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, saturation, wrap, quadrant folds
        queue_force(32'h0, 32'h0, 32'h0);
        queue_force(32'h7fffffff, 32'h80000000, 32'h40000000);
        queue_force(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        queue_force(32'h80000000, 32'h7fffffff, 32'h80000000);
        queue_force(32'hffffffff, 32'h1, 32'hffffffff);
        queue_force(32'h80000000, 32'h80000000, 32'h80000000);
        queue_force(32'h00010000, 32'hffff0000, 32'h20000000);
        run_batch(0, 0);

        write_reg(REG_TIME_STEP, StepOne);
        write_reg(REG_HALF_WIDTH, 32'h7fffffff);
        write_reg(REG_HALF_HEIGHT, 32'h7fffffff);
        write_reg(REG_START_X, 32'h7fff0000);
        write_reg(REG_START_Y, 32'h80000000);
        queue_force(32'h0, 32'h0, 32'h40000000);
        queue_force(32'h0, 32'h0, 32'h40000000);
        queue_force(32'h7fffffff, 32'h80000000, 32'h3fffffff);
        run_batch(6, 1);

        // time step above one acts as one; zero scalings
        write_reg(REG_TIME_STEP, 32'h1ffff);
        write_reg(REG_INV_MASS, 32'h0);
        write_reg(REG_INV_INERTIA, 32'hffffffff);
        run_batch(4, 1);
        write_reg(REG_INV_MASS, 32'hffffffff);
        write_reg(REG_INV_INERTIA, 32'h0);
        write_reg(REG_TIME_STEP, 32'h0);
        run_batch(4, 1);

        // random phases with fresh settings
        for (int p = 0; p < 12; p++)
        begin
            write_reg(REG_INV_MASS, (p % 4 == 0) ? rand_edge32() : $urandom_range(0, 262144));
            write_reg(REG_INV_INERTIA, (p % 4 == 1) ? rand_edge32() : $urandom_range(0, 262144));
            write_reg(REG_HALF_WIDTH, (p % 3 == 0) ? $urandom : $urandom_range(0, 1 << 22));
            write_reg(REG_HALF_HEIGHT, (p % 3 == 1) ? $urandom : $urandom_range(0, 1 << 22));
            write_reg(REG_TIME_STEP, $urandom_range(0, 131071));
            write_reg(REG_START_X, (p % 2) ? rand_edge32() : $urandom);
            write_reg(REG_START_Y, (p % 2) ? $urandom : rand_edge32());
            run_batch(150, (p % 3 == 2));
        end
        driving_done = 1;

        $display("covered %0d force words over 16 register phases, %0d results checked",
                 words_sent, words_checked);
        if (errors == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatching results", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #10000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
